// ===== design/sgs_pkg.sv =====
// Shared types, constants and helpers of the shell gravity source block.
// No dependencies.
package sgs_pkg;

  localparam int unsigned FracBitsDef = 40;
  localparam int unsigned ValW = 63;

  localparam logic [1:0] CfgGravConst   = 2'd0;
  localparam logic [1:0] CfgCentralMass = 2'd1;
  localparam logic [1:0] CfgEnergyMode  = 2'd2;

  // Operation codes of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV
  } sgs_op_e;

  typedef struct packed {
    logic    start;
    sgs_op_e op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] lim;
  } sgs_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic        sat;
  } sgs_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQO,
    ST_CROSS,
    ST_SQI,
    ST_SUMS,
    ST_RATIO,
    ST_PART,
    ST_NUM,
    ST_ACCEL,
    ST_RHOA,
    ST_MOM,
    ST_ENERGY,
    ST_FINISH,
    ST_OUT
  } sgs_state_e;

  localparam logic [63:0] Max63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegLim = 64'h8000_0000_0000_0000;

  // Saturating add of two 63-bit magnitudes.
  function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y,
                                          output logic hit);
    logic [63:0] s;
    s = {1'b0, x[62:0]} + {1'b0, y[62:0]};
    hit = s[63];
    return s[63] ? Max63 : s;
  endfunction

endpackage

// ===== design/shell_gravity_source.sv =====
// Shell gravity source, top level: sequencer, registers and result stage.
// Depends on sgs_pkg and sgs_arith.
//
// Usage: program grav_const, central_mass and energy_mode through the write
// port (cfg_we_i, cfg_idx_i, cfg_wdata_i) while idle. Present shells from the
// center outward on the request channel (in_valid_i, in_stall_o); mark the
// innermost one with start_of_grid_i. Each request yields one result on the
// output channel (out_valid_o, out_stall_i).
// Each request issues up to eight multiplies and two divides (seven
// multiplies in energy mode 1), all one after another to the single shared
// unit; divide is one bit a cycle. A new request is taken the cycle after
// the result leaves.
// in_stall_o stays high while a request is in work or a result is held.
// Reset clears the configuration registers and the enclosed mass to zero; a stalled result
// holds in its output register until taken.
module shell_gravity_source #(
  parameter int unsigned FracBits = sgs_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [62:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_of_grid_i,
  input  logic [62:0] outer_radius_i,
  input  logic [62:0] shell_width_i,
  input  logic [62:0] shell_mass_i,
  input  logic [62:0] density_i,
  input  logic signed [63:0] velocity_i,
  input  logic [62:0] volume_dt_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [63:0] momentum_delta_o,
  output logic signed [63:0] energy_delta_o,
  output logic [62:0] mass_enclosed_o,
  output logic        saturated_o
);

  logic [62:0] gconst_q, cmass_q;
  logic        emode_q;
  logic [62:0] encl_q, encl_d;

  sgs_pkg::sgs_state_e state_q, state_d;
  logic                issued_q, issued_d;

  logic [63:0] ro_q, ri_q, msh_q, dens_q, vdt_q, vel_q;
  logic [63:0] ro_d, ri_d;
  logic [63:0] below_q, below_d;
  logic [63:0] sqo_q, sqo_d, cross_q, cross_d, sqi_q, sqi_d;
  logic [63:0] sum_q, sum_d, wsum_q, wsum_d;
  logic [63:0] t_q, t_d;
  logic [63:0] mom_q, mom_d, en_q, en_d;
  logic        sat_q, sat_d;

  logic [63:0] mom_out_q, en_out_q;
  logic [62:0] encl_out_q;
  logic        sat_out_q;
  logic        ovalid_q, ovalid_d;
  logic        load_out;

  sgs_pkg::sgs_req_t req;
  sgs_pkg::sgs_rsp_t rsp;

  logic in_acc, out_acc;
  logic h1, h2, h3, h4, h5, h6, h7, h8;
  logic [63:0] s1, s2, s3, s4, s5, inner, num3, vneg, encl_sum;

  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != sgs_pkg::ST_IDLE) || ovalid_q;

  sgs_arith #(.FracBits(FracBits)) u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always_comb begin
    s1    = sgs_pkg::sat_add(sqo_q, cross_q, h1);
    s2    = sgs_pkg::sat_add(s1, sqi_q, h2);
    s3    = sgs_pkg::sat_add(s2, cross_q, h3);
    s4    = sgs_pkg::sat_add(s3, sqi_q, h4);
    s5    = sgs_pkg::sat_add(s4, sqi_q, h5);
    inner = sgs_pkg::sat_add(below_q, {2'b00, rsp.res[63:2]}, h6);
    num3  = sgs_pkg::sat_add(sgs_pkg::sat_add(rsp.res, rsp.res, h7), rsp.res, h7);
    vneg  = 64'd0 - vel_q;
    encl_sum = sgs_pkg::sat_add(below_q, msh_q, h8);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sgs_pkg::ST_IDLE:   if (in_acc) state_d = sgs_pkg::ST_SQO;
      sgs_pkg::ST_SQO:    if (rsp.done) state_d = sgs_pkg::ST_CROSS;
      sgs_pkg::ST_CROSS:  if (rsp.done) state_d = sgs_pkg::ST_SQI;
      sgs_pkg::ST_SQI:    if (rsp.done) state_d = sgs_pkg::ST_SUMS;
      sgs_pkg::ST_SUMS:   state_d = (s2 == '0) ? sgs_pkg::ST_NUM : sgs_pkg::ST_RATIO;
      sgs_pkg::ST_RATIO:  if (rsp.done) state_d = sgs_pkg::ST_PART;
      sgs_pkg::ST_PART:   if (rsp.done) state_d = sgs_pkg::ST_NUM;
      sgs_pkg::ST_NUM:    if (rsp.done) state_d = sgs_pkg::ST_ACCEL;
      sgs_pkg::ST_ACCEL:  if (rsp.done || (issued_q && sum_q == '0)) state_d = sgs_pkg::ST_RHOA;
      sgs_pkg::ST_RHOA:   if (rsp.done) state_d = sgs_pkg::ST_MOM;
      sgs_pkg::ST_MOM:    if (rsp.done) state_d = emode_q ? sgs_pkg::ST_FINISH
                                                          : sgs_pkg::ST_ENERGY;
      sgs_pkg::ST_ENERGY: if (rsp.done) state_d = sgs_pkg::ST_FINISH;
      sgs_pkg::ST_FINISH: state_d = sgs_pkg::ST_OUT;
      sgs_pkg::ST_OUT:    if (!ovalid_q) state_d = sgs_pkg::ST_IDLE;
      default:            state_d = sgs_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit requests
  always_comb begin
    req      = '{start: 1'b0, op: sgs_pkg::OP_MUL, a: '0, b: '0, lim: sgs_pkg::Max63};
    issued_d = issued_q;
    ro_d = ro_q; ri_d = ri_q; below_d = below_q;
    sqo_d = sqo_q; cross_d = cross_q; sqi_d = sqi_q;
    sum_d = sum_q; wsum_d = wsum_q; t_d = t_q;
    mom_d = mom_q; en_d = en_q; sat_d = sat_q;
    encl_d = encl_q;
    load_out = 1'b0;
    unique case (state_q)
      sgs_pkg::ST_IDLE: begin
        if (in_acc) begin
          ro_d    = {1'b0, outer_radius_i};
          below_d = {1'b0, start_of_grid_i ? cmass_q : encl_q};
          sat_d   = (shell_width_i == '0) || (shell_width_i > outer_radius_i);
          ri_d    = (shell_width_i > outer_radius_i) ? 64'd0
                    : {1'b0, outer_radius_i - shell_width_i};
          sqo_d = '0; cross_d = '0; sqi_d = '0; t_d = '0; en_d = '0;
        end
      end
      sgs_pkg::ST_SQO, sgs_pkg::ST_CROSS, sgs_pkg::ST_SQI: begin
        req.start = !issued_q;
        issued_d  = 1'b1;
        req.a     = (state_q == sgs_pkg::ST_SQI) ? ri_q : ro_q;
        req.b     = (state_q == sgs_pkg::ST_SQO) ? ro_q : ri_q;
        if (rsp.done) begin
          sat_d = sat_q | rsp.sat;
          if (state_q == sgs_pkg::ST_SQO) sqo_d = rsp.res;
          else if (state_q == sgs_pkg::ST_CROSS) cross_d = rsp.res;
          else sqi_d = rsp.res;
        end
      end
      sgs_pkg::ST_SUMS: begin
        sum_d  = s2;
        wsum_d = s5;
        sat_d  = sat_q | h1 | h2 | h3 | h4 | h5;
      end
      sgs_pkg::ST_RATIO: begin
        req.start = !issued_q; issued_d = 1'b1;
        req.op = sgs_pkg::OP_DIV; req.a = wsum_q; req.b = sum_q;
        if (rsp.done) begin
          t_d = rsp.res; sat_d = sat_q | rsp.sat;
        end
      end
      sgs_pkg::ST_PART: begin
        req.start = !issued_q; issued_d = 1'b1;
        req.a = msh_q; req.b = t_q;
        if (rsp.done) begin
          t_d = inner; sat_d = sat_q | rsp.sat | h6;
        end
      end
      sgs_pkg::ST_NUM: begin
        req.start = !issued_q; issued_d = 1'b1;
        // with S zero the ratio is zero and inner is just the held mass
        req.a = {1'b0, gconst_q};
        req.b = (sum_q == '0) ? below_q : t_q;
        if (rsp.done) begin
          t_d = num3; sat_d = sat_q | rsp.sat | h7;
        end
      end
      sgs_pkg::ST_ACCEL: begin
        issued_d = 1'b1;
        if (sum_q == '0) begin
          if (!issued_q && t_q != '0) begin
            t_d = sgs_pkg::Max63; sat_d = 1'b1;
          end
        end else begin
          req.start = !issued_q;
          req.op = sgs_pkg::OP_DIV; req.a = t_q; req.b = sum_q;
          if (rsp.done) begin
            t_d = rsp.res; sat_d = sat_q | rsp.sat;
          end
        end
      end
      sgs_pkg::ST_RHOA, sgs_pkg::ST_MOM: begin
        req.start = !issued_q; issued_d = 1'b1;
        req.a = (state_q == sgs_pkg::ST_RHOA) ? dens_q : t_q;
        req.b = (state_q == sgs_pkg::ST_RHOA) ? t_q : vdt_q;
        if (rsp.done) begin
          t_d = rsp.res; sat_d = sat_q | rsp.sat;
          if (state_q == sgs_pkg::ST_MOM) mom_d = rsp.res;
        end
      end
      sgs_pkg::ST_ENERGY: begin
        req.start = !issued_q; issued_d = 1'b1;
        req.a   = mom_q;
        req.b   = vel_q[63] ? vneg : vel_q;
        req.lim = vel_q[63] ? sgs_pkg::Max63 : sgs_pkg::NegLim;
        if (rsp.done) begin
          en_d  = vel_q[63] ? rsp.res : 64'd0 - rsp.res;
          sat_d = sat_q | rsp.sat;
        end
      end
      sgs_pkg::ST_FINISH: begin
        encl_d   = encl_sum[62:0];
        sat_d    = sat_q | h8;
      end
      sgs_pkg::ST_OUT: load_out = !ovalid_q;
      default: ;
    endcase
    // rearm the issue flag for the next step
    if (state_d != state_q) issued_d = 1'b0;
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (out_acc) ovalid_d = 1'b0;
    if (load_out) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sgs_pkg::ST_IDLE;
      issued_q <= 1'b0;
      ovalid_q <= 1'b0;
      gconst_q <= '0;
      cmass_q  <= '0;
      emode_q  <= 1'b0;
      encl_q   <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      ovalid_q <= ovalid_d;
      encl_q   <= encl_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sgs_pkg::CfgGravConst:   gconst_q <= cfg_wdata_i;
          sgs_pkg::CfgCentralMass: cmass_q  <= cfg_wdata_i;
          sgs_pkg::CfgEnergyMode:  emode_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ro_q <= ro_d; ri_q <= ri_d; below_q <= below_d;
    sqo_q <= sqo_d; cross_q <= cross_d; sqi_q <= sqi_d;
    sum_q <= sum_d; wsum_q <= wsum_d; t_q <= t_d;
    mom_q <= mom_d; en_q <= en_d; sat_q <= sat_d;
    if (in_acc) begin
      msh_q  <= {1'b0, shell_mass_i};
      dens_q <= {1'b0, density_i};
      vdt_q  <= {1'b0, volume_dt_i};
      vel_q  <= velocity_i;
    end
    if (load_out) begin
      mom_out_q  <= 64'd0 - mom_q;
      en_out_q   <= en_q;
      encl_out_q <= encl_q;
      sat_out_q  <= sat_q;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign momentum_delta_o = mom_out_q;
  assign energy_delta_o   = en_out_q;
  assign mass_enclosed_o  = encl_out_q;
  assign saturated_o      = sat_out_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sgs_pkg::ST_IDLE) |-> in_stall_o) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(momentum_delta_o))
    else $error("result dropped while stalled");
  a_load_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> state_q == sgs_pkg::ST_IDLE) else $error("result not released");
  a_mode1_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && emode_q) |=> energy_delta_o == '0) else $error("energy in mode 1");

endmodule

// ===== design/sgs_arith.sv =====
// Shared multiply/divide unit: fixed point multiply by 16x64 partial products
// and restoring divide one quotient bit a cycle. Depends on sgs_pkg.
module sgs_arith #(
  parameter int unsigned FracBits = sgs_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgs_pkg::sgs_req_t req_i,
  output sgs_pkg::sgs_rsp_t rsp_o
);

  localparam int unsigned CntW = 7;

  logic              busy_q, busy_d;
  sgs_pkg::sgs_op_e  op_q, op_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [127:0]      acc_q, acc_d;
  logic [63:0]       a_q, a_d;
  logic [63:0]       b_q, b_d;
  logic [63:0]       lim_q, lim_d;
  logic [63:0]       rem_q, rem_d;
  logic [63:0]       lo_q, lo_d;
  logic [63:0]       quo_q, quo_d;
  logic              done_q, done_d;
  logic [63:0]       res_q, res_d;
  logic              sat_q, sat_d;

  logic [79:0]  pp;
  logic [63:0]  rem_sh;
  logic         top;

  always_comb begin
    pp      = a_q * {64'd0, b_q[15:0]};
    top     = rem_q[63];
    rem_sh  = {rem_q[62:0], lo_q[63]};
  end

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    lim_d  = lim_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    res_d  = res_q;
    sat_d  = sat_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      a_d    = req_i.a;
      b_d    = req_i.b;
      lim_d  = req_i.lim;
      acc_d  = '0;
      cnt_d  = '0;
      rem_d  = req_i.a >> (64 - FracBits);
      lo_d   = req_i.a << FracBits;
      quo_d  = '0;
    end else if (busy_q) begin
      unique case (op_q)
        sgs_pkg::OP_MUL: begin
          // accumulate one 16-bit slice of b per cycle, least significant first
          acc_d = acc_q + ({48'd0, pp} << (7'(cnt_q[1:0]) << 4));
          b_d   = b_q >> 16;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntW'(3)) begin
            busy_d = 1'b0;
            done_d = 1'b1;
            if ((acc_d >> (64 + FracBits)) != 128'd0 ||
                128'(acc_d >> FracBits) > {64'd0, lim_q}) begin
              res_d = lim_q;
              sat_d = 1'b1;
            end else begin
              res_d = acc_d[FracBits +: 64];
              sat_d = 1'b0;
            end
          end
        end
        sgs_pkg::OP_DIV: begin
          if (cnt_q == '0 && rem_q >= b_q) begin
            busy_d = 1'b0;
            done_d = 1'b1;
            res_d  = lim_q;
            sat_d  = 1'b1;
          end else begin
            lo_d  = lo_q << 1;
            cnt_d = cnt_q + 1'b1;
            if (top || rem_sh >= b_q) begin
              rem_d = rem_sh - b_q;
              quo_d = {quo_q[62:0], 1'b1};
            end else begin
              rem_d = rem_sh;
              quo_d = {quo_q[62:0], 1'b0};
            end
            if (cnt_q == CntW'(63)) begin
              busy_d = 1'b0;
              done_d = 1'b1;
              sat_d  = quo_d > lim_q;
              res_d  = (quo_d > lim_q) ? lim_q : quo_d;
            end
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= sgs_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    lim_q <= lim_d;
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    res_q <= res_d;
    sat_q <= sat_d;
  end

  assign rsp_o = '{done: done_q, res: res_q, sat: sat_q};

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_sat_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> res_q <= lim_q) else $error("result above limit");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= CntW'(63)) else $error("count out of range");

endmodule
